### design/cst_pkg.sv
// ----------------------------------------------------------------------------
// cst_pkg: shared types and constants of the character stream tokenizer
// Scan modes, token kinds, the token word and the push bundle into the queue.
// ----------------------------------------------------------------------------
package cst_pkg;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_IDENT,
		MODE_NUMBER,
		MODE_STRING
	} mode_t;

	typedef enum logic [3:0] {
		KIND_LET     = 4'd0,
		KIND_PRINT   = 4'd1,
		KIND_IDENT   = 4'd2,
		KIND_NUMBER  = 4'd3,
		KIND_STRING  = 4'd4,
		KIND_EQ      = 4'd5,
		KIND_PLUS    = 4'd6,
		KIND_MINUS   = 4'd7,
		KIND_MUL     = 4'd8,
		KIND_DIV     = 4'd9,
		KIND_EOF     = 4'd10,
		KIND_UNKNOWN = 4'd11
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] line;
		logic [15:0] column;
		logic [15:0] offset;
		logic [15:0] length;
		logic        last;
	} token_t;

	// Tokens produced by one byte, first in stream order.
	typedef struct packed {
		logic [1:0] count;
		token_t     first;
		token_t     second;
	} token_push_t;

	localparam logic [7:0] CH_END        = 8'h00;
	localparam logic [7:0] CH_NEWLINE    = 8'h0A;
	localparam logic [7:0] CH_SPACE      = 8'h20;
	localparam logic [7:0] CH_QUOTE      = 8'h22;
	localparam logic [7:0] CH_MUL        = 8'h2A;
	localparam logic [7:0] CH_PLUS       = 8'h2B;
	localparam logic [7:0] CH_MINUS      = 8'h2D;
	localparam logic [7:0] CH_DIV        = 8'h2F;
	localparam logic [7:0] CH_EQ         = 8'h3D;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

	// Keyword letters, upper case.
	localparam logic [7:0] CH_C = 8'h43;
	localparam logic [7:0] CH_E = 8'h45;
	localparam logic [7:0] CH_H = 8'h48;
	localparam logic [7:0] CH_I = 8'h49;
	localparam logic [7:0] CH_L = 8'h4C;
	localparam logic [7:0] CH_N = 8'h4E;
	localparam logic [7:0] CH_O = 8'h4F;
	localparam logic [7:0] CH_P = 8'h50;
	localparam logic [7:0] CH_R = 8'h52;
	localparam logic [7:0] CH_T = 8'h54;

endpackage

### design/cst_scan.sv
// ----------------------------------------------------------------------------
// cst_scan: per-byte scanner state and token builder
// Holds position counters and scan mode; one byte is consumed per step and
// zero, one or two tokens are produced for the queue.
// ----------------------------------------------------------------------------
module cst_scan #(
	parameter int COUNT_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step_en,
	input  logic [7:0]           char_code,
	output cst_pkg::token_push_t push
);
	import cst_pkg::*;

	localparam int W = COUNT_BITS;
	localparam logic [W-1:0] CNT_MAX = {W{1'b1}};
	localparam logic [W-1:0] CNT_ONE = W'(1);

	mode_t        mode_q, mode_d;
	logic [W-1:0] off_q, off_d;
	logic [W-1:0] line_q, line_d;
	logic [W-1:0] col_q, col_d;
	logic [W-1:0] start_off_q, start_off_d;
	logic [W-1:0] start_col_q, start_col_d;
	logic [W-1:0] run_q, run_d;
	logic [2:0]   kw_live_q, kw_live_d;
	logic [2:0]   kw_idx_q, kw_idx_d;

	function automatic logic [W-1:0] sat_inc(input logic [W-1:0] v);
		return (v == CNT_MAX) ? CNT_MAX : v + CNT_ONE;
	endfunction

	function automatic logic [15:0] clamp16(input logic [W-1:0] v);
		logic [W+15:0] ext;
		ext = {16'd0, v};
		if (ext > (W+16)'(17'h0FFFF)) begin
			return 16'hFFFF;
		end
		return ext[15:0];
	endfunction

	// Advance the keyword matcher by one upper-case byte: {idx, live}.
	function automatic logic [5:0] kw_feed(input logic [2:0] live, input logic [2:0] idx,
			input logic [7:0] up);
		logic [7:0] let_ch;
		logic [7:0] print_ch;
		logic [7:0] echo_ch;
		logic [2:0] nlive;
		logic [2:0] nidx;
		case (idx)
			3'd0: begin let_ch = CH_L; print_ch = CH_P; echo_ch = CH_E; end
			3'd1: begin let_ch = CH_E; print_ch = CH_R; echo_ch = CH_C; end
			3'd2: begin let_ch = CH_T; print_ch = CH_I; echo_ch = CH_H; end
			3'd3: begin let_ch = CH_END; print_ch = CH_N; echo_ch = CH_O; end
			3'd4: begin let_ch = CH_END; print_ch = CH_T; echo_ch = CH_END; end
			default: begin let_ch = CH_END; print_ch = CH_END; echo_ch = CH_END; end
		endcase
		nlive[0] = live[0] && (idx < 3'd3) && (let_ch == up);
		nlive[1] = live[1] && (idx < 3'd5) && (print_ch == up);
		nlive[2] = live[2] && (idx < 3'd4) && (echo_ch == up);
		nidx = (idx < 3'd7) ? idx + 3'd1 : idx;
		return {nidx, nlive};
	endfunction

	logic       is_alpha, is_digit, is_space, is_word;
	logic [7:0] up;
	logic [5:0] feed_cur, feed_fresh;
	kind_t      ident_kind, op_kind;
	logic [W-1:0] adv_off, adv_line, adv_col;
	logic       a_valid, b_valid, run_idle;
	token_t     tok_a, tok_b;

	always_comb begin
		is_alpha = (char_code inside {[8'h41:8'h5A], [8'h61:8'h7A]});
		is_digit = (char_code inside {[8'h30:8'h39]});
		is_space = (char_code == CH_SPACE) || (char_code inside {[8'h09:8'h0D]});
		is_word  = is_alpha || is_digit || (char_code == CH_UNDERSCORE);
		up = (char_code inside {[8'h61:8'h7A]}) ? char_code - 8'h20 : char_code;
		feed_cur   = kw_feed(kw_live_q, kw_idx_q, up);
		feed_fresh = kw_feed(3'b111, 3'd0, up);

		if (kw_live_q[0] && kw_idx_q == 3'd3) begin
			ident_kind = KIND_LET;
		end else if (kw_live_q[1] && kw_idx_q == 3'd5) begin
			ident_kind = KIND_PRINT;
		end else if (kw_live_q[2] && kw_idx_q == 3'd4) begin
			ident_kind = KIND_PRINT;
		end else begin
			ident_kind = KIND_IDENT;
		end

		case (char_code)
			CH_EQ:    op_kind = KIND_EQ;
			CH_PLUS:  op_kind = KIND_PLUS;
			CH_MINUS: op_kind = KIND_MINUS;
			CH_MUL:   op_kind = KIND_MUL;
			CH_DIV:   op_kind = KIND_DIV;
			default:  op_kind = KIND_UNKNOWN;
		endcase

		adv_off = sat_inc(off_q);
		if (char_code == CH_NEWLINE) begin
			adv_line = sat_inc(line_q);
			adv_col  = '0;
		end else begin
			adv_line = line_q;
			adv_col  = sat_inc(col_q);
		end

		mode_d      = mode_q;
		off_d       = off_q;
		line_d      = line_q;
		col_d       = col_q;
		start_off_d = start_off_q;
		start_col_d = start_col_q;
		run_d       = run_q;
		kw_live_d   = kw_live_q;
		kw_idx_d    = kw_idx_q;
		a_valid     = 1'b0;
		b_valid     = 1'b0;
		run_idle    = 1'b0;

		tok_a.kind   = KIND_STRING;
		tok_a.line   = clamp16(line_q);
		tok_a.column = clamp16(start_col_q);
		tok_a.offset = clamp16(start_off_q);
		tok_a.length = clamp16(run_q);
		tok_a.last   = 1'b0;

		tok_b.kind   = op_kind;
		tok_b.line   = clamp16(line_q);
		tok_b.column = clamp16(col_q);
		tok_b.offset = clamp16(off_q);
		tok_b.length = 16'd1;
		tok_b.last   = 1'b1;

		case (mode_q)
			MODE_IDENT: begin
				if (is_word) begin
					{kw_idx_d, kw_live_d} = feed_cur;
					run_d  = sat_inc(run_q);
					off_d  = adv_off;
					line_d = adv_line;
					col_d  = adv_col;
				end else begin
					a_valid    = 1'b1;
					tok_a.kind = ident_kind;
					mode_d     = MODE_IDLE;
					run_idle   = 1'b1;
				end
			end
			MODE_NUMBER: begin
				if (is_digit) begin
					run_d  = sat_inc(run_q);
					off_d  = adv_off;
					line_d = adv_line;
					col_d  = adv_col;
				end else begin
					a_valid    = 1'b1;
					tok_a.kind = KIND_NUMBER;
					mode_d     = MODE_IDLE;
					run_idle   = 1'b1;
				end
			end
			MODE_STRING: begin
				if (char_code == CH_QUOTE) begin
					a_valid = 1'b1;
					mode_d  = MODE_IDLE;
					off_d   = adv_off;
					line_d  = adv_line;
					col_d   = adv_col;
				end else if (char_code != CH_END) begin
					run_d  = sat_inc(run_q);
					off_d  = adv_off;
					line_d = adv_line;
					col_d  = adv_col;
				end else begin
					// unterminated string closes at end of text, then eof follows
					a_valid  = 1'b1;
					mode_d   = MODE_IDLE;
					run_idle = 1'b1;
				end
			end
			default: begin
				run_idle = 1'b1;
			end
		endcase

		if (run_idle) begin
			if (char_code == CH_END) begin
				b_valid      = 1'b1;
				tok_b.kind   = KIND_EOF;
				tok_b.length = 16'd0;
				mode_d       = MODE_IDLE;
				off_d        = '0;
				line_d       = CNT_ONE;
				col_d        = '0;
				start_off_d  = '0;
				start_col_d  = '0;
				run_d        = '0;
				kw_live_d    = 3'b111;
				kw_idx_d     = 3'd0;
			end else if (is_space) begin
				off_d  = adv_off;
				line_d = adv_line;
				col_d  = adv_col;
			end else if (is_alpha || is_digit) begin
				start_off_d = off_q;
				start_col_d = col_q;
				run_d       = CNT_ONE;
				if (is_alpha) begin
					{kw_idx_d, kw_live_d} = feed_fresh;
					mode_d = MODE_IDENT;
				end else begin
					kw_live_d = 3'b111;
					kw_idx_d  = 3'd0;
					mode_d    = MODE_NUMBER;
				end
				off_d  = adv_off;
				line_d = adv_line;
				col_d  = adv_col;
			end else if (char_code == CH_QUOTE) begin
				start_col_d = col_q;
				start_off_d = adv_off;
				run_d       = '0;
				mode_d      = MODE_STRING;
				off_d       = adv_off;
				line_d      = adv_line;
				col_d       = adv_col;
			end else begin
				b_valid = 1'b1;
				off_d   = adv_off;
				line_d  = adv_line;
				col_d   = adv_col;
			end
		end

		// order: closing token first, fresh token second; flag the final one
		push = '0;
		if (step_en) begin
			if (a_valid && b_valid) begin
				push.count  = 2'd2;
				push.first  = tok_a;
				push.second = tok_b;
			end else if (a_valid) begin
				push.count      = 2'd1;
				push.first      = tok_a;
				push.first.last = 1'b1;
			end else if (b_valid) begin
				push.count = 2'd1;
				push.first = tok_b;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			off_q       <= '0;
			line_q      <= CNT_ONE;
			col_q       <= '0;
			start_off_q <= '0;
			start_col_q <= '0;
			run_q       <= '0;
			kw_live_q   <= 3'b111;
			kw_idx_q    <= 3'd0;
		end else if (step_en) begin
			mode_q      <= mode_d;
			off_q       <= off_d;
			line_q      <= line_d;
			col_q       <= col_d;
			start_off_q <= start_off_d;
			start_col_q <= start_col_d;
			run_q       <= run_d;
			kw_live_q   <= kw_live_d;
			kw_idx_q    <= kw_idx_d;
		end
	end

endmodule

### design/cst_token_fifo.sv
// ----------------------------------------------------------------------------
// cst_token_fifo: four-entry token queue
// Takes up to two tokens a cycle, hands one a cycle to the output channel while out_ready is high.
// ----------------------------------------------------------------------------
module cst_token_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cst_pkg::token_push_t push,
	output logic                 room,
	output logic                 out_valid,
	input  logic                 out_ready,
	output cst_pkg::token_t      head
);
	import cst_pkg::*;

	localparam int DEPTH = 4;
	localparam int PTR_BITS = $clog2(DEPTH);

	token_t              mem_q [DEPTH];
	logic [PTR_BITS-1:0] wr_q, rd_q;
	logic [PTR_BITS:0]   count_q;
	logic                pop;
	logic [PTR_BITS-1:0] wr_next;

	assign room      = (count_q <= (PTR_BITS+1)'(DEPTH - 2));
	assign out_valid = (count_q != '0);
	assign head      = mem_q[rd_q];
	assign pop       = out_valid && out_ready;
	assign wr_next   = wr_q + PTR_BITS'(1);

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_next] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + PTR_BITS'(push.count);
			rd_q    <= rd_q + PTR_BITS'(pop);
			count_q <= count_q + (PTR_BITS+1)'(push.count) - (PTR_BITS+1)'(pop);
		end
	end

endmodule

### design/char_stream_tokenizer.sv
// ----------------------------------------------------------------------------
// char_stream_tokenizer: streaming lexical tokenizer
// One source byte in per word, up to two tokens out per byte.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready, char_code): one source byte per word;
// byte 0 ends the text, emits eof and returns position to offset 0, line 1.
// Output channel (out_valid/out_ready, token_*): one token per word, with
// last_of_item set on the final token caused by a byte.
// Timing: a byte is captured in the input register when it is accepted and
// scanned once the queue has room for two tokens; that step writes its tokens
// into the queue, whose head drives the output directly.
// Throughput: one byte per cycle while the token queue has room. The
// scanner steps only when the four-entry token queue has room for two
// tokens; when the receiver stalls the queue fills, the input register holds
// its byte and in_ready drops until the queue drains.
// Reset (arst_n low): scan mode idle, offset/column/run zero, line one,
// keyword matcher cleared, queue and input register empty.
// ----------------------------------------------------------------------------
module char_stream_tokenizer #(
	parameter int COUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_code,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  token_kind,
	output logic [15:0] token_line,
	output logic [15:0] token_column,
	output logic [15:0] token_offset,
	output logic [15:0] token_length,
	output logic        last_of_item
);
	import cst_pkg::*;

	// input register: holds one byte until the scanner takes it
	logic        valid_s1;
	logic [7:0]  char_s1;
	logic        room;
	logic        step;
	token_push_t push;
	token_t      head;

	// advance the scanner whenever a byte waits and the queue can absorb two
	assign step     = valid_s1 && room;
	assign in_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload needs no reset: qualified by valid_s1
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= char_code;
		end
	end

	cst_scan #(
		.COUNT_BITS(COUNT_BITS)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.step_en  (step),
		.char_code(char_s1),
		.push     (push)
	);

	cst_token_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.room     (room),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.head     (head)
	);

	// drive the token word straight from the queue head
	assign token_kind   = head.kind;
	assign token_line   = head.line;
	assign token_column = head.column;
	assign token_offset = head.offset;
	assign token_length = head.length;
	assign last_of_item = head.last;

endmodule
